/* sv/assert_macros.svh */
// Assertion macros shared by the filter RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FMLVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmlvf: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define FMLVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmlvf: next-cycle check failed");

`endif

/* sv/fmlvf_pkg.sv */
// Package for the FM synthesizer level/volume filter.
// Types, register codes and address decode tables; no dependencies.
package fmlvf_pkg;

  localparam int unsigned CH_IDX_W = 4;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_KEY_OFF = 2'd1;
  localparam logic [1:0] OP_RELEVEL = 2'd2;

  localparam logic CFG_VOLUME = 1'b0;
  localparam logic CFG_MUTE   = 1'b1;

  localparam logic [2:0] LEVEL_HI = 3'b010;  // 0x40-0x5F
  localparam logic [3:0] FREQ_HI  = 4'hB;
  localparam logic [3:0] CONN_HI  = 4'hC;
  localparam logic [5:0] ATT_MAX  = 6'h3F;
  localparam logic [8:0] VOL_UNITY = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY_OFF,
    ST_RELEVEL
  } fmlvf_state_t;

  typedef struct packed {
    logic [CH_IDX_W-1:0] ch;
    logic [1:0]          opr;  // 2 marks an unused offset
  } lvl_map_t;

  // Level register offset (0..31) to channel and operator.
  function automatic lvl_map_t lvl_map(input logic [4:0] ofs);
    lvl_map_t m;
    logic [CH_IDX_W-1:0] grp;
    grp = {2'b00, ofs[4:3]} + {1'b0, ofs[4:3], 1'b0};
    case (ofs[2:0])
      3'd0: begin m.ch = grp;         m.opr = 2'd0; end
      3'd1: begin m.ch = grp + 4'd1;  m.opr = 2'd0; end
      3'd2: begin m.ch = grp + 4'd2;  m.opr = 2'd0; end
      3'd3: begin m.ch = grp;         m.opr = 2'd1; end
      3'd4: begin m.ch = grp + 4'd1;  m.opr = 2'd1; end
      3'd5: begin m.ch = grp + 4'd2;  m.opr = 2'd1; end
      default: begin m.ch = grp;      m.opr = 2'd2; end
    endcase
    return m;
  endfunction

  // Channel and operator to level register offset.
  function automatic logic [4:0] lvl_offset(input logic [CH_IDX_W-1:0] ch, input logic opr);
    logic [4:0] base;
    case (ch)
      4'd0: base = 5'd0;
      4'd1: base = 5'd1;
      4'd2: base = 5'd2;
      4'd3: base = 5'd8;
      4'd4: base = 5'd9;
      4'd5: base = 5'd10;
      4'd6: base = 5'd16;
      4'd7: base = 5'd17;
      4'd8: base = 5'd18;
      default: base = 5'd0;
    endcase
    return opr ? base + 5'd3 : base;
  endfunction

endpackage

/* sv/fmlvf_if.sv */
// Valid/ready channel interfaces for the filter's input and result streams.
// Depends on fmlvf_pkg (none of its items beyond the import).
interface fmlvf_in_if import fmlvf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;

  modport source (output valid, op, reg_addr, reg_data, input ready);
  modport sink   (input valid, op, reg_addr, reg_data, output ready);
endinterface

interface fmlvf_out_if import fmlvf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_addr;
  logic [7:0] out_data;
  logic       last;

  modport source (output valid, out_addr, out_data, last, input ready);
  modport sink   (input valid, out_addr, out_data, last, output ready);
endinterface

/* sv/fmlvf_scale.sv */
// Shared level scaling unit: rescales a 6-bit attenuation by master volume.
// Depends on fmlvf_pkg for constants.
module fmlvf_scale import fmlvf_pkg::*; (
  input  logic [7:0] stored,
  input  logic       scale_en,
  input  logic [8:0] volume,
  input  logic       mute,
  output logic [7:0] level
);

  logic [8:0]  vol_clamped;
  logic [5:0]  inv;
  logic [14:0] prod;
  logic [5:0]  inv_scaled;

  always_comb begin
    vol_clamped = (volume > VOL_UNITY) ? VOL_UNITY : volume;
    inv         = ATT_MAX - stored[5:0];
    prod        = {9'd0, inv} * {6'd0, vol_clamped};
    inv_scaled  = mute ? 6'd0 : prod[13:8];
    if (scale_en) begin
      level = {stored[7:6], ATT_MAX - inv_scaled};
    end else begin
      level = stored;
    end
  end

endmodule

/* sv/fm_synth_level_volume_filter.sv */
// A register write (op 0) is registered and appears at the output in the cycle after its transfer;
// one write per cycle is sustained while the result side keeps taking.
// Key-off (op 1) emits NUM_CHANNELS writes and level reapply (op 2) 2*NUM_CHANNELS, one per
// cycle while the result side keeps taking; input is held off until the last one is loaded.
// Reset (rst_n, synchronous): shadow tables zero, volume 256, mute off; no clearing pass.
module fm_synth_level_volume_filter import fmlvf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fmlvf_in_if.sink             in_ch,
  fmlvf_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [8:0]           cfg_wdata
);

  localparam int unsigned CH_W = $clog2(NUM_CHANNELS);
  localparam logic [CH_IDX_W-1:0] NCH = CH_IDX_W'(NUM_CHANNELS);
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  fmlvf_state_t state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            opr_r, opr_nxt;

  logic [8:0] volume_r;
  logic       mute_r;

  logic [7:0] mod_level_r [NUM_CHANNELS];
  logic [7:0] car_level_r [NUM_CHANNELS];
  logic [4:0] freq_r      [NUM_CHANNELS];
  logic       add_r       [NUM_CHANNELS];

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_addr_r, out_addr_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  logic       load_ok, accept, load;
  lvl_map_t   lmap;
  logic       lvl_ok, freq_ok, conn_ok;
  logic [CH_IDX_W-1:0] sel_ch;
  logic [CH_W-1:0]     sel_idx;
  logic [CH_W-1:0]     nib_idx;
  logic [7:0] sc_stored;
  logic       sc_opr;
  logic [7:0] sc_level;

  assign load_ok      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && load_ok;
  assign accept       = in_ch.valid && in_ch.ready;

  // Address decode of the incoming write
  always_comb begin
    lmap    = lvl_map(in_ch.reg_addr[4:0]);
    lvl_ok  = (in_ch.reg_addr[7:5] == LEVEL_HI) && (lmap.opr != 2'd2) && (lmap.ch < NCH);
    freq_ok = (in_ch.reg_addr[7:4] == FREQ_HI) && (in_ch.reg_addr[3:0] < NCH);
    conn_ok = (in_ch.reg_addr[7:4] == CONN_HI) && (in_ch.reg_addr[3:0] < NCH);
    nib_idx = in_ch.reg_addr[CH_W-1:0];
  end

  // Operand select for the shared scaling unit
  always_comb begin
    if (state_r == ST_IDLE) begin
      sel_ch = lmap.ch;
    end else begin
      sel_ch = CH_IDX_W'(ch_r);
    end
    sel_idx = (sel_ch < NCH) ? sel_ch[CH_W-1:0] : '0;
    if (state_r == ST_IDLE) begin
      sc_stored = in_ch.reg_data;
      sc_opr    = lmap.opr[0];
    end else begin
      sc_stored = opr_r ? car_level_r[sel_idx] : mod_level_r[sel_idx];
      sc_opr    = opr_r;
    end
  end

  fmlvf_scale u_scale (
    .stored   (sc_stored),
    .scale_en (add_r[sel_idx] || sc_opr),
    .volume   (volume_r),
    .mute     (mute_r),
    .level    (sc_level)
  );

  // Sequencer and output register next state
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    opr_nxt       = opr_r;
    load          = 1'b0;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        ch_nxt  = '0;
        opr_nxt = 1'b0;
        if (accept) begin
          case (in_ch.op)
            OP_WRITE: begin
              load         = 1'b1;
              out_addr_nxt = in_ch.reg_addr;
              out_data_nxt = lvl_ok ? sc_level : in_ch.reg_data;
              out_last_nxt = 1'b1;
            end
            OP_KEY_OFF: state_nxt = ST_KEY_OFF;
            OP_RELEVEL: state_nxt = ST_RELEVEL;
            default: ;
          endcase
        end
      end
      ST_KEY_OFF: begin
        if (load_ok) begin
          load         = 1'b1;
          out_addr_nxt = {FREQ_HI, CH_IDX_W'(ch_r)};
          out_data_nxt = {3'd0, freq_r[ch_r]};
          out_last_nxt = (ch_r == LAST_CH);
          if (ch_r == LAST_CH) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end
      end
      ST_RELEVEL: begin
        if (load_ok) begin
          load         = 1'b1;
          out_addr_nxt = {LEVEL_HI, lvl_offset(CH_IDX_W'(ch_r), opr_r)};
          out_data_nxt = sc_level;
          out_last_nxt = (ch_r == LAST_CH) && opr_r;
          opr_nxt      = !opr_r;
          if (opr_r) begin
            if (ch_r == LAST_CH) begin
              state_nxt = ST_IDLE;
            end else begin
              ch_nxt = ch_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      opr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      opr_r       <= opr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOL_UNITY;
      mute_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLUME: volume_r <= cfg_wdata;
        CFG_MUTE:   mute_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Shadow tables, updated on op 0 transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mod_level_r[i] <= '0;
        car_level_r[i] <= '0;
        freq_r[i]      <= '0;
        add_r[i]       <= 1'b0;
      end
    end else if (accept && (in_ch.op == OP_WRITE)) begin
      if (lvl_ok) begin
        if (lmap.opr[0]) begin
          car_level_r[sel_idx] <= in_ch.reg_data;
        end else begin
          mod_level_r[sel_idx] <= in_ch.reg_data;
        end
      end
      if (freq_ok) begin
        freq_r[nib_idx] <= in_ch.reg_data[4:0];  // key-on bit dropped
      end
      if (conn_ok) begin
        add_r[nib_idx] <= in_ch.reg_data[0];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_addr = out_addr_r;
  assign out_ch.out_data = out_data_r;
  assign out_ch.last     = out_last_r;

`include "assert_macros.svh"

  `FMLVF_ASSERT_IMP(a_busy_blocks_input, state_r != ST_IDLE, !in_ch.ready)
  `FMLVF_ASSERT_NXT(a_keyoff_starts, accept && (in_ch.op == OP_KEY_OFF),
                    (state_r == ST_KEY_OFF) && (ch_r == '0))
  `FMLVF_ASSERT_NXT(a_sweep_ends_last, (state_r != ST_IDLE) && (state_nxt == ST_IDLE),
                    out_valid_r && out_last_r)
  `FMLVF_ASSERT_IMP(a_ch_in_range, state_r != ST_IDLE, ch_r <= LAST_CH)

endmodule

/* verif/fm_synth_level_volume_filter_chk.sv */
// Checker for the FM synth level/volume filter: watches both channels and the register port,
// predicts every synthesizer write and compares the results in order.
// Depends on fmlvf_pkg and the channel interfaces in fmlvf_if.sv.
module fm_synth_level_volume_filter_chk import fmlvf_pkg::*; #(
  parameter int unsigned NCH = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  fmlvf_in_if         in_mon,
  fmlvf_out_if        out_mon,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata,
  output int unsigned fail_count,
  output int unsigned backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } synth_write_t;

  logic [7:0]   mod_lvl     [NCH];
  logic [7:0]   car_lvl     [NCH];
  logic [4:0]   freq_shadow [NCH];
  logic         additive    [NCH];
  logic [8:0]   volume;
  logic         muted;
  synth_write_t pending_writes [$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [7:0] level_addr(input int unsigned ch, input bit carrier);
    int unsigned ofs;
    ofs = (ch / 3) * 8 + ch % 3 + (carrier ? 3 : 0);
    return {LEVEL_HI, ofs[4:0]};
  endfunction

  // Carriers, and both operators of an additive channel, follow the volume.
  function automatic logic [7:0] scaled_level(input int unsigned ch, input bit carrier);
    logic [7:0]  stored;
    logic [8:0]  gain;
    logic [14:0] prod;
    logic [5:0]  lift;
    stored = carrier ? car_lvl[ch] : mod_lvl[ch];
    if (!(additive[ch] || carrier))
      return stored;
    gain = (volume > VOL_UNITY) ? VOL_UNITY : volume;
    prod = 15'(ATT_MAX - stored[5:0]) * 15'(gain);
    lift = muted ? 6'd0 : prod[13:8];
    return {stored[7:6], ATT_MAX - lift};
  endfunction

  function automatic void predict_writes(input logic [1:0] op, input logic [7:0] addr,
                                         input logic [7:0] data);
    int unsigned ofs;
    int unsigned ch;
    int unsigned opr;
    logic [7:0]  sent;
    sent = data;
    case (op)
      OP_WRITE: begin
        if (addr[7:5] == LEVEL_HI) begin
          ofs = 32'(addr[4:0]);
          ch  = (ofs / 8) * 3 + (ofs % 8) % 3;
          opr = (ofs % 8) / 3;
          if (opr < 2 && ch < NCH) begin
            if (opr == 0) mod_lvl[ch] = data;
            else car_lvl[ch] = data;
            sent = scaled_level(ch, opr == 1);
          end
        end else if (addr[7:4] == FREQ_HI) begin
          if (addr[3:0] < NCH) freq_shadow[addr[3:0]] = data[4:0];
        end else if (addr[7:4] == CONN_HI) begin
          if (addr[3:0] < NCH) additive[addr[3:0]] = data[0];
        end
        pending_writes.push_back(synth_write_t'{addr, sent, 1'b1});
      end
      OP_KEY_OFF: begin
        for (int i = 0; i < NCH; i++)
          pending_writes.push_back(synth_write_t'{{FREQ_HI, i[3:0]}, {3'b000, freq_shadow[i]},
                                                  i == NCH - 1});
      end
      OP_RELEVEL: begin
        for (int i = 0; i < NCH; i++) begin
          pending_writes.push_back(synth_write_t'{level_addr(i, 1'b0), scaled_level(i, 1'b0),
                                                  1'b0});
          pending_writes.push_back(synth_write_t'{level_addr(i, 1'b1), scaled_level(i, 1'b1),
                                                  i == NCH - 1});
        end
      end
      default: ;  // no writes, no state change
    endcase
  endfunction

  always @(posedge clk) begin
    synth_write_t want;
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        mod_lvl[i]     = '0;
        car_lvl[i]     = '0;
        freq_shadow[i] = '0;
        additive[i]    = 1'b0;
      end
      volume = VOL_UNITY;
      muted  = 1'b0;
      pending_writes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_VOLUME) volume = cfg_wdata;
        else muted = cfg_wdata[0];
      end
      // drain first: a result never belongs to the item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (pending_writes.size() == 0) begin
          report($sformatf("unexpected write addr=%h data=%h last=%b",
                           out_mon.out_addr, out_mon.out_data, out_mon.last));
        end else begin
          want = pending_writes.pop_front();
          if (out_mon.out_addr !== want.addr)
            report($sformatf("addr %h, expected %h", out_mon.out_addr, want.addr));
          if (out_mon.out_data !== want.data)
            report($sformatf("data %h, expected %h (addr %h)", out_mon.out_data, want.data,
                             want.addr));
          if (out_mon.last !== want.last)
            report($sformatf("last %b, expected %b (addr %h)", out_mon.last, want.last,
                             want.addr));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_writes(in_mon.op, in_mon.reg_addr, in_mon.reg_data);
    end
    backlog <= pending_writes.size();
  end

endmodule

/* verif/fm_synth_level_volume_filter_tb.sv */
// Top of the level/volume filter bench: clock, reset, stimulus, verdict.
// Instantiates the filter and its checker; uses fmlvf_pkg and the channel interfaces.
module fm_synth_level_volume_filter_tb import fmlvf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH         = 9;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 2 * NCH + 4;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 33;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_VOLUME;
  logic [8:0]  cfg_wdata = '0;
  logic        quiet = 1'b0;
  int unsigned fail_count;
  int unsigned backlog;
  int unsigned cycles = 0;
  logic [8:0]  vol_plan  [PHASES] = '{9'd256, 9'd0, 9'd511, 9'd257, 9'd128, 9'd1, 9'd255, 9'd0};
  logic        mute_plan [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  fmlvf_in_if  in_ch ();
  fmlvf_out_if out_ch ();

  fm_synth_level_volume_filter #(.NUM_CHANNELS(NCH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fm_synth_level_volume_filter_chk #(.NCH(NCH)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fm_synth_level_volume_filter verification failed");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] addr, input logic [7:0] data);
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.reg_addr <= addr;
    in_ch.reg_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain(input int unsigned settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // cfg_we stays high across both writes
  task automatic program_volume(input logic [8:0] vol, input logic [8:0] mute_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_index <= CFG_MUTE;
    cfg_wdata <= mute_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly decoded registers in use, with a share of sweeps and stray writes.
  task automatic random_item(output logic [1:0] op, output logic [7:0] addr,
                             output logic [7:0] data);
    int unsigned pick;
    pick = $urandom_range(99);
    op   = OP_WRITE;
    addr = 8'($urandom);
    data = 8'($urandom);
    if (pick < 40) begin
      addr[7:5] = LEVEL_HI;
    end else if (pick < 55) begin
      addr[7:4] = FREQ_HI;
      if (pick % 4 != 0) addr[3:0] = 4'($urandom_range(NCH - 1));
    end else if (pick < 70) begin
      addr[7:4] = CONN_HI;
      if (pick % 4 != 0) addr[3:0] = 4'($urandom_range(NCH - 1));
    end else if (pick < 82) begin
      op = OP_WRITE;
    end else if (pick < 89) begin
      op = OP_KEY_OFF;
    end else if (pick < 97) begin
      op = OP_RELEVEL;
    end else begin
      op = OP_UNUSED;
    end
  endtask

  initial begin
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [8:0]  word;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_WRITE;
    in_ch.reg_addr = '0;
    in_ch.reg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass at reset volume
    send(OP_RELEVEL, 8'hFF, 8'hFF);
    send(OP_KEY_OFF, 8'h00, 8'h00);
    send(OP_WRITE, 8'hC0, 8'h01);
    send(OP_WRITE, 8'hC8, 8'hFF);
    send(OP_WRITE, 8'hCD, 8'h01);  // channel past the last one
    send(OP_WRITE, 8'h40, 8'hFF);
    send(OP_WRITE, 8'h43, 8'h00);
    send(OP_WRITE, 8'h55, 8'hC0);
    send(OP_WRITE, 8'h52, 8'h7A);
    send(OP_WRITE, 8'h41, 8'h2B);
    send(OP_WRITE, 8'h46, 8'h33);  // unused level offset
    send(OP_WRITE, 8'h5A, 8'h15);
    send(OP_WRITE, 8'h5F, 8'hFF);
    send(OP_WRITE, 8'hB0, 8'hFF);  // key-on bit set
    send(OP_WRITE, 8'hB8, 8'h3F);
    send(OP_WRITE, 8'hBD, 8'hAA);
    send(OP_WRITE, 8'hBF, 8'h20);
    send(OP_WRITE, 8'h00, 8'h00);
    send(OP_WRITE, 8'hFF, 8'hFF);
    send(OP_WRITE, 8'h3F, 8'h80);
    send(OP_UNUSED, 8'hA5, 8'h5A);
    send(OP_KEY_OFF, 8'h12, 8'h34);
    send(OP_RELEVEL, 8'h00, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      drain(4);
      word    = 9'($urandom);
      word[0] = (p == PHASES - 1) ? 1'($urandom_range(1)) : mute_plan[p];
      program_volume((p == PHASES - 1) ? 9'($urandom_range(511)) : vol_plan[p], word);
      quiet <= (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(op, addr, data);
        send(op, addr, data);
      end
    end

    drain(SETTLE);
    if (fail_count == 0 && backlog == 0)
      $display("fm_synth_level_volume_filter verification clean");
    else
      $display("fm_synth_level_volume_filter verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/fmlvf_pkg.sv
sv/fmlvf_if.sv
sv/fmlvf_scale.sv
sv/fm_synth_level_volume_filter.sv
verif/fm_synth_level_volume_filter_chk.sv
verif/fm_synth_level_volume_filter_tb.sv
